FILE: hdl/shp_pkg.sv
// Package with symbol codes, status codes, sequencer states and shared types.
package shp_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SYM_W = 3;
    localparam int DEPTH_W = 7;
    localparam int RED_W = 7;

    typedef enum logic [SYM_W-1:0] {
        SYM_I    = 3'd0,
        SYM_E    = 3'd1,
        SYM_PLUS = 3'd2,
        SYM_STAR = 3'd3,
        SYM_LP   = 3'd4,
        SYM_RP   = 3'd5,
        SYM_NONE = 3'd7
    } sym_t;

    typedef enum logic [2:0] {
        STAT_SHIFTED  = 3'd0,
        STAT_INVALID  = 3'd1,
        STAT_ACCEPT   = 3'd2,
        STAT_REJECT   = 3'd3,
        STAT_OVERFLOW = 3'd4,
        STAT_IGNORED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SETTLE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic step;
        logic pop;
    } red_dec_t;

    function automatic sym_t code_of(input logic [7:0] ch);
        sym_t code;
        unique case (ch)
            8'h69:   code = SYM_I;
            8'h2B:   code = SYM_PLUS;
            8'h2A:   code = SYM_STAR;
            8'h28:   code = SYM_LP;
            8'h29:   code = SYM_RP;
            default: code = SYM_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: hdl/shift_reduce_expression_parser.sv
// Top level: shift-reduce recognizer for the grammar E -> E+E | E*E | (E) | i.
// Reductions are made one at a time by a single compare unit reading the top
// register and the two entries below it in a stack RAM; an id reduction stays in
// the evaluate state, a three-symbol reduction also passes through a settle state.
// A new beat is taken once the result is loaded and the sequencer is back in idle.
// Reset is asynchronous and clears the count, error flag, sequencer and result
// valid; the stack RAM itself is not cleared.
module shift_reduce_expression_parser
    import shp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [7:0]         symbol,
    input  logic               end_mark,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         status,
    output logic [DEPTH_W-1:0] stack_depth,
    output logic [RED_W-1:0]   reductions_done
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    sym_t               top_reg, top_next;
    logic               err_reg, err_next;
    sym_t               sym_reg, sym_next;
    logic               end_reg, end_next;
    logic [RED_W-1:0]   red_reg, red_next;
    logic               result_valid_reg, result_valid_next;
    status_t            status_reg, status_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [RED_W-1:0]   rdone_reg, rdone_next;

    logic                     accept;
    logic                     commit;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    sym_t                     wr_data;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic [SYM_W-1:0]         rd_data_a;
    logic [SYM_W-1:0]         rd_data_b;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         cnt_m2;
    logic [CNT_W-1:0]         cnt_m3;
    logic [CNT_W+DEPTH_W-1:0] cnt_ext;
    sym_t                     lookahead;
    red_dec_t                 dec;
    status_t                  fin_status;
    logic [CNT_W-1:0]         fin_cnt;

    assign item_stall      = (state_reg != ST_IDLE);
    assign accept          = item_valid && !item_stall;
    assign commit          = (state_reg == ST_FINISH) && (!result_valid_reg || !result_stall);
    assign result_valid    = result_valid_reg;
    assign status          = status_reg;
    assign stack_depth     = depth_reg;
    assign reductions_done = rdone_reg;

    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cnt_m2    = cnt_reg - CNT_W'(2);
    assign cnt_m3    = cnt_reg - CNT_W'(3);
    assign rd_addr_a = cnt_m2[ADDR_W-1:0];
    assign rd_addr_b = cnt_m3[ADDR_W-1:0];
    assign lookahead = end_reg ? SYM_NONE : sym_reg;
    assign cnt_ext   = {{DEPTH_W{1'b0}}, fin_cnt};

    shp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    shp_reduce_unit u_reduce (
        .count     (cnt_reg),
        .top0      (top_reg),
        .top1      (sym_t'(rd_data_a)),
        .top2      (sym_t'(rd_data_b)),
        .lookahead (lookahead),
        .dec       (dec)
    );

    always_comb
    begin
        fin_cnt    = cnt_reg;
        fin_status = STAT_SHIFTED;
        if (end_reg)
        begin
            fin_cnt = '0;
            if (!err_reg && (cnt_reg == CNT_W'(1)) && (top_reg == SYM_E))
            begin
                fin_status = STAT_ACCEPT;
            end
            else
            begin
                fin_status = STAT_REJECT;
            end
        end
        else if (err_reg)
        begin
            fin_status = STAT_IGNORED;
        end
        else if (sym_reg == SYM_NONE)
        begin
            fin_status = STAT_INVALID;
        end
        else if (cnt_reg >= CNT_W'(STACK_DEPTH))
        begin
            fin_status = STAT_OVERFLOW;
        end
        else
        begin
            fin_cnt = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (err_reg || !dec.step)
                begin
                    state_next = ST_FINISH;
                end
                else if (dec.pop)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_EVAL;
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next          = cnt_reg;
        top_next          = top_reg;
        err_next          = err_reg;
        sym_next          = sym_reg;
        end_next          = end_reg;
        red_next          = red_reg;
        result_valid_next = result_valid_reg && result_stall;
        status_next       = status_reg;
        depth_next        = depth_reg;
        rdone_next        = rdone_reg;
        wr_en             = 1'b0;
        wr_addr           = cnt_reg[ADDR_W-1:0];
        wr_data           = SYM_E;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sym_next = code_of(symbol);
                    end_next = end_mark;
                    red_next = '0;
                end
            end
            ST_EVAL:
            begin
                if (!err_reg && dec.step)
                begin
                    top_next = SYM_E;
                    wr_en    = 1'b1;
                    red_next = (red_reg == {RED_W{1'b1}}) ? red_reg : red_reg + RED_W'(1);
                    if (dec.pop)
                    begin
                        cnt_next = cnt_m2;
                        wr_addr  = cnt_m3[ADDR_W-1:0];
                    end
                    else
                    begin
                        wr_addr = cnt_m1[ADDR_W-1:0];
                    end
                end
            end
            ST_SETTLE:
            begin
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    cnt_next          = fin_cnt;
                    result_valid_next = 1'b1;
                    status_next       = fin_status;
                    depth_next        = cnt_ext[DEPTH_W-1:0];
                    rdone_next        = red_reg;
                    if (end_reg)
                    begin
                        err_next = 1'b0;
                    end
                    else if ((fin_status == STAT_INVALID) || (fin_status == STAT_OVERFLOW))
                    begin
                        err_next = 1'b1;
                    end
                    else if (fin_status == STAT_SHIFTED)
                    begin
                        wr_en    = 1'b1;
                        wr_data  = sym_reg;
                        top_next = sym_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            err_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        sym_reg    <= sym_next;
        end_reg    <= end_next;
        red_reg    <= red_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
        rdone_reg  <= rdone_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETTLE) |-> (cnt_reg + CNT_W'(2) == $past(cnt_reg)))
        else $error("three-symbol reduction did not pop two entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && end_reg) |=> ((cnt_reg == '0) && !err_reg))
        else $error("end of string did not clear stack and error");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (status_reg == STAT_IGNORED)) |-> (rdone_reg == '0))
        else $error("ignored beat reports reductions");
`endif

endmodule

FILE: hdl/shp_ram.sv
// Generic RAM with one write port and two registered read ports.
module shp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: hdl/shp_reduce_unit.sv
// Compare unit that decides the next reduction from the top three stack symbols and the lookahead.
module shp_reduce_unit
    import shp_pkg::*;
(
    input  logic [CNT_W-1:0] count,
    input  sym_t             top0,
    input  sym_t             top1,
    input  sym_t             top2,
    input  sym_t             lookahead,
    output red_dec_t         dec
);

    logic has1;
    logic has3;
    logic e_plus_e;
    logic e_star_e;
    logic paren_e;
    logic blocked;

    always_comb
    begin
        has1     = (count >= CNT_W'(1));
        has3     = (count >= CNT_W'(3));
        e_plus_e = has3 && (top2 == SYM_E) && (top1 == SYM_PLUS) && (top0 == SYM_E);
        e_star_e = has3 && (top2 == SYM_E) && (top1 == SYM_STAR) && (top0 == SYM_E);
        paren_e  = has3 && (top2 == SYM_LP) && (top1 == SYM_E) && (top0 == SYM_RP);
        blocked  = e_plus_e && (lookahead == SYM_STAR);
        dec.step = 1'b0;
        dec.pop  = 1'b0;
        if (!blocked)
        begin
            if (has1 && (top0 == SYM_I))
            begin
                dec.step = 1'b1;
            end
            else if (e_star_e || e_plus_e || paren_e)
            begin
                dec.step = 1'b1;
                dec.pop  = 1'b1;
            end
        end
    end

endmodule
